>>> design/oas_pkg.sv
// Shared types and constants for the obstacle avoidance sequencer.
package oas_pkg;

  localparam int unsigned MODE_W   = 4;
  localparam int unsigned DRIVE_W  = 2;
  localparam int unsigned AIM_W    = 2;
  localparam int unsigned PULSE_W  = 6;
  localparam int unsigned TICKS_W  = 11;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Mode codes as they appear on the result
  localparam logic [MODE_W-1:0] MODE_OFF    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_MOVING = 4'd1;
  localparam logic [MODE_W-1:0] MODE_NEED   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_AVOID  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_LOOK_R = 4'd4;
  localparam logic [MODE_W-1:0] MODE_LOOK_L = 4'd5;
  localparam logic [MODE_W-1:0] MODE_TURN_R = 4'd6;
  localparam logic [MODE_W-1:0] MODE_TURN_L = 4'd7;
  localparam logic [MODE_W-1:0] MODE_TURN_A = 4'd8;

  localparam logic [DRIVE_W-1:0] DRV_STOP   = 2'd0;
  localparam logic [DRIVE_W-1:0] DRV_FWD    = 2'd1;
  localparam logic [DRIVE_W-1:0] DRV_SPIN_R = 2'd2;
  localparam logic [DRIVE_W-1:0] DRV_SPIN_L = 2'd3;

  localparam logic [AIM_W-1:0] AIM_CENTER = 2'd0;
  localparam logic [AIM_W-1:0] AIM_RIGHT  = 2'd1;
  localparam logic [AIM_W-1:0] AIM_LEFT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_QUARTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 2'd2;

  localparam logic [PULSE_W-1:0] QUARTER_RESET = 6'd19;
  localparam logic [PULSE_W-1:0] HALF_RESET    = 6'd38;
  localparam logic [TICKS_W-1:0] SETTLE_RESET  = 11'd1500;
  localparam logic [PULSE_W-1:0] PULSE_MAX     = 6'd63;

  typedef enum logic [8:0] {
    ST_OFF    = 9'b000000001,
    ST_MOVING = 9'b000000010,
    ST_NEED   = 9'b000000100,
    ST_AVOID  = 9'b000001000,
    ST_LOOK_R = 9'b000010000,
    ST_LOOK_L = 9'b000100000,
    ST_TURN_R = 9'b001000000,
    ST_TURN_L = 9'b010000000,
    ST_TURN_A = 9'b100000000
  } mode_t;

  typedef struct packed {
    logic run_enable;
    logic obstacle_seen;
    logic encoder_pulse;
    logic coin_bit;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DRIVE_W-1:0] motor_drive;
    logic [AIM_W-1:0]   servo_aim;
    logic               vacuum_on;
    logic               obstacle_flag;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      ST_OFF:    c = MODE_OFF;
      ST_MOVING: c = MODE_MOVING;
      ST_NEED:   c = MODE_NEED;
      ST_AVOID:  c = MODE_AVOID;
      ST_LOOK_R: c = MODE_LOOK_R;
      ST_LOOK_L: c = MODE_LOOK_L;
      ST_TURN_R: c = MODE_TURN_R;
      ST_TURN_L: c = MODE_TURN_L;
      ST_TURN_A: c = MODE_TURN_A;
      default:   c = MODE_OFF;
    endcase
    return c;
  endfunction

endpackage

>>> design/oas_ctrl.sv
// Mode sequencer state, configuration registers and per-tick transition logic.
module oas_ctrl #(
  parameter int unsigned SETTLE_BITS = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  oas_pkg::cfg_wr_t   cfg,
  input  logic               advance,
  input  oas_pkg::in_item_t  item,
  output oas_pkg::out_item_t result
);
  import oas_pkg::*;

  localparam int unsigned CMP_W = (SETTLE_BITS > TICKS_W) ? SETTLE_BITS : TICKS_W;
  localparam logic [SETTLE_BITS-1:0] SETTLE_MAX = {SETTLE_BITS{1'b1}};

  logic [PULSE_W-1:0] quarter_turn_pulses;
  logic [PULSE_W-1:0] half_turn_pulses;
  logic [TICKS_W-1:0] servo_settle_ticks;

  mode_t                  mode_reg, mode_reg_next;
  mode_t                  previous_mode, previous_mode_next;
  logic                   obstacle_latch, obstacle_latch_next;
  logic [SETTLE_BITS-1:0] settle_count, settle_count_next;
  logic                   look_active, look_active_next;
  logic                   turn_active, turn_active_next;
  logic [PULSE_W-1:0]     pulse_count, pulse_count_next;
  logic                   suction_enable, suction_enable_next;

  logic [DRIVE_W-1:0]     drive;
  logic [AIM_W-1:0]       aim;
  logic [SETTLE_BITS-1:0] settle_inc;
  logic                   settle_done;
  logic [PULSE_W:0]       pulse_total;
  logic [PULSE_W-1:0]     turn_limit;
  logic                   look_right;
  mode_t                  other_look;

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_turn_pulses <= QUARTER_RESET;
      half_turn_pulses    <= HALF_RESET;
      servo_settle_ticks  <= SETTLE_RESET;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_QUARTER: quarter_turn_pulses <= cfg.data[PULSE_W-1:0];
        REG_HALF:    half_turn_pulses    <= cfg.data[PULSE_W-1:0];
        REG_SETTLE:  servo_settle_ticks  <= cfg.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    settle_inc  = (settle_count < SETTLE_MAX) ? settle_count + 1'b1 : settle_count;
    settle_done = (CMP_W'(settle_inc) >= CMP_W'(servo_settle_ticks))
                  || (settle_inc == SETTLE_MAX);
    pulse_total = {1'b0, pulse_count} + {{PULSE_W{1'b0}}, item.encoder_pulse};
    turn_limit  = (mode_reg == ST_TURN_A) ? half_turn_pulses : quarter_turn_pulses;
    look_right  = (mode_reg == ST_LOOK_R);
    other_look  = look_right ? ST_LOOK_L : ST_LOOK_R;
  end

  always_comb begin
    mode_reg_next       = mode_reg;
    previous_mode_next  = previous_mode;
    obstacle_latch_next = obstacle_latch;
    settle_count_next   = settle_count;
    look_active_next    = look_active;
    turn_active_next    = turn_active;
    pulse_count_next    = pulse_count;
    suction_enable_next = suction_enable;
    drive               = DRV_STOP;
    aim                 = AIM_CENTER;

    case (mode_reg)
      ST_OFF: begin
        suction_enable_next = 1'b1;
        if (item.run_enable) begin
          previous_mode_next = mode_reg;
          mode_reg_next      = ST_MOVING;
        end
      end
      ST_MOVING: begin
        drive               = DRV_FWD;
        obstacle_latch_next = item.obstacle_seen;
        if (item.obstacle_seen) begin
          previous_mode_next = mode_reg;
          mode_reg_next      = ST_NEED;
        end
      end
      ST_NEED: begin
        obstacle_latch_next = item.obstacle_seen;
        previous_mode_next  = mode_reg;
        mode_reg_next       = item.obstacle_seen ? ST_AVOID : ST_MOVING;
      end
      ST_AVOID: begin
        previous_mode_next = mode_reg;
        mode_reg_next      = item.coin_bit ? ST_LOOK_L : ST_LOOK_R;
      end
      ST_LOOK_R, ST_LOOK_L: begin
        if (!look_active) begin
          settle_count_next = '0;
          look_active_next  = 1'b1;
          aim               = look_right ? AIM_RIGHT : AIM_LEFT;
        end else begin
          settle_count_next = settle_inc;
          if (settle_done) begin
            // sample, recenter and pick the next mode in the same tick
            look_active_next    = 1'b0;
            obstacle_latch_next = item.obstacle_seen;
            previous_mode_next  = mode_reg;
            if (!item.obstacle_seen) begin
              mode_reg_next = look_right ? ST_TURN_R : ST_TURN_L;
            end else if (previous_mode != other_look) begin
              mode_reg_next = other_look;
            end else begin
              mode_reg_next = ST_TURN_A;
            end
          end else begin
            aim = look_right ? AIM_RIGHT : AIM_LEFT;
          end
        end
      end
      ST_TURN_R, ST_TURN_L, ST_TURN_A: begin
        if (!turn_active) begin
          // first tick of a turn drops the pulse
          pulse_count_next = '0;
          turn_active_next = 1'b1;
          drive            = (mode_reg == ST_TURN_R) ? DRV_SPIN_R : DRV_SPIN_L;
        end else begin
          pulse_count_next = pulse_total[PULSE_W] ? PULSE_MAX : pulse_total[PULSE_W-1:0];
          if (pulse_total > {1'b0, turn_limit}) begin
            turn_active_next   = 1'b0;
            previous_mode_next = mode_reg;
            mode_reg_next      = ST_MOVING;
          end else begin
            drive = (mode_reg == ST_TURN_R) ? DRV_SPIN_R : DRV_SPIN_L;
          end
        end
      end
      default: ;
    endcase

    result.mode          = mode_code(mode_reg_next);
    result.motor_drive   = drive;
    result.servo_aim     = aim;
    result.vacuum_on     = suction_enable_next;
    result.obstacle_flag = obstacle_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= ST_OFF;
      previous_mode  <= ST_OFF;
      obstacle_latch <= 1'b0;
      settle_count   <= '0;
      look_active    <= 1'b0;
      turn_active    <= 1'b0;
      pulse_count    <= '0;
      suction_enable <= 1'b0;
    end else if (advance) begin
      mode_reg       <= mode_reg_next;
      previous_mode  <= previous_mode_next;
      obstacle_latch <= obstacle_latch_next;
      settle_count   <= settle_count_next;
      look_active    <= look_active_next;
      turn_active    <= turn_active_next;
      pulse_count    <= pulse_count_next;
      suction_enable <= suction_enable_next;
    end
  end

endmodule

>>> design/obstacle_avoid_sequencer_core.sv
// Top level of the obstacle avoidance sequencer: handshake and result register.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data   (oas_pkg::in_item_t)
//   out     | output    | out_valid/out_stall| out_data  (oas_pkg::out_item_t)
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One request per clock while in_stall is low: a tick's transition is computed
// combinationally and its result lands in the output register on the accepting
// edge, which also sets the registered out_valid.
// in_stall is raised only while a result waits in the output register and
// out_stall holds it. Synchronous reset puts the mode in off and loads the
// register defaults.
module obstacle_avoid_sequencer_core #(
  parameter int unsigned SETTLE_BITS = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  oas_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output oas_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [oas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [oas_pkg::CFG_W-1:0]         cfg_data
);
  import oas_pkg::*;

  cfg_wr_t   cfg;
  out_item_t result;
  logic      advance;

  assign cfg      = '{we: cfg_we, index: cfg_index, data: cfg_data};
  assign in_stall = out_valid && out_stall;
  assign advance  = in_valid && !in_stall;

  oas_ctrl #(
    .SETTLE_BITS(SETTLE_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (in_data),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

>>> dv/tb.sv
// Testbench for obstacle_avoid_sequencer_core: directed script, then random control ticks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oas_pkg::*;

  localparam int unsigned SETTLE_BITS = 11;
  localparam int unsigned SETTLE_MAX  = (1 << SETTLE_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic {ROW_TICK, ROW_REG} script_op_t;

  typedef struct packed {
    script_op_t           op;
    in_item_t             stim;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    bit                   typed;
    out_item_t            want;
  } script_row_t;

  typedef struct packed {
    logic [PULSE_W-1:0] quarter;
    logic [PULSE_W-1:0] half;
    logic [TICKS_W-1:0] settle;
    int                 items;
    bit                 gaps;
    bit                 stalls;
  } phase_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  bit          send_gaps = 1'b1;
  bit          stall_gaps = 1'b1;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  out_item_t   results_due[$];

  // controller state as the block should hold it
  logic [MODE_W-1:0]  ctl_mode = MODE_OFF;
  logic [MODE_W-1:0]  ctl_prev_mode = MODE_OFF;
  logic               ctl_seen = 1'b0;
  int unsigned        ctl_settle = 0;
  logic               ctl_looking = 1'b0;
  logic               ctl_turning = 1'b0;
  logic [PULSE_W-1:0] ctl_pulses = '0;
  logic               ctl_suction = 1'b0;
  logic [PULSE_W-1:0] reg_quarter = QUARTER_RESET;
  logic [PULSE_W-1:0] reg_half = HALF_RESET;
  logic [TICKS_W-1:0] reg_settle = SETTLE_RESET;

  obstacle_avoid_sequencer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void change_mode(logic [MODE_W-1:0] nxt);
    ctl_prev_mode = ctl_mode;
    ctl_mode = nxt;
  endfunction

  function automatic out_item_t advance_controller(in_item_t it);
    logic [DRIVE_W-1:0] drv;
    logic [DRIVE_W-1:0] spin;
    logic [AIM_W-1:0]   aim;
    logic [MODE_W-1:0]  other;
    logic [PULSE_W-1:0] limit;
    logic               right;
    logic               sampled;
    logic               done;
    int unsigned        total;
    drv = DRV_STOP;
    aim = AIM_CENTER;
    case (ctl_mode)
      MODE_OFF: begin
        ctl_suction = 1'b1;
        if (it.run_enable) change_mode(MODE_MOVING);
      end
      MODE_MOVING: begin
        drv = DRV_FWD;
        ctl_seen = it.obstacle_seen;
        if (ctl_seen) change_mode(MODE_NEED);
      end
      MODE_NEED: begin
        ctl_seen = it.obstacle_seen;
        change_mode(ctl_seen ? MODE_AVOID : MODE_MOVING);
      end
      MODE_AVOID: begin
        change_mode(it.coin_bit ? MODE_LOOK_L : MODE_LOOK_R);
      end
      MODE_LOOK_R, MODE_LOOK_L: begin
        right = (ctl_mode == MODE_LOOK_R);
        other = right ? MODE_LOOK_L : MODE_LOOK_R;
        sampled = 1'b0;
        if (!ctl_looking) begin
          ctl_settle = 0;
          ctl_looking = 1'b1;
        end else begin
          if (ctl_settle < SETTLE_MAX) ctl_settle++;
          sampled = (ctl_settle >= reg_settle) || (ctl_settle == SETTLE_MAX);
        end
        if (!sampled) begin
          aim = right ? AIM_RIGHT : AIM_LEFT;
        end else begin
          ctl_looking = 1'b0;
          ctl_seen = it.obstacle_seen;
          // second blocked look in a row means turn around
          if (!ctl_seen) change_mode(right ? MODE_TURN_R : MODE_TURN_L);
          else if (ctl_prev_mode != other) change_mode(other);
          else change_mode(MODE_TURN_A);
        end
      end
      MODE_TURN_R, MODE_TURN_L, MODE_TURN_A: begin
        limit = (ctl_mode == MODE_TURN_A) ? reg_half : reg_quarter;
        spin = (ctl_mode == MODE_TURN_R) ? DRV_SPIN_R : DRV_SPIN_L;
        done = 1'b0;
        if (!ctl_turning) begin
          // pulse on the opening tick is dropped
          ctl_pulses = '0;
          ctl_turning = 1'b1;
        end else begin
          total = ctl_pulses + it.encoder_pulse;
          ctl_pulses = (total > PULSE_MAX) ? PULSE_MAX : total[PULSE_W-1:0];
          done = total > limit;
        end
        if (done) begin
          ctl_turning = 1'b0;
          change_mode(MODE_MOVING);
        end else begin
          drv = spin;
        end
      end
      default: begin
      end
    endcase
    return '{ctl_mode, drv, aim, ctl_suction, ctl_seen};
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bias inputs by mode so most ticks walk the full avoid sequence
  function automatic in_item_t shape_tick();
    in_item_t    s;
    int unsigned obs_pct;
    s = in_item_t'(4'($urandom_range(0, 15)));
    if ($urandom_range(0, 9) == 0) return s;
    case (ctl_mode)
      MODE_MOVING: obs_pct = 25;
      MODE_NEED:   obs_pct = 70;
      default:     obs_pct = 50;
    endcase
    s.run_enable = ($urandom_range(0, 9) != 0);
    s.obstacle_seen = ($urandom_range(0, 99) < obs_pct);
    s.encoder_pulse = ($urandom_range(0, 9) < 7);
    return s;
  endfunction

  function automatic script_row_t plain_row(in_item_t s);
    return '{ROW_TICK, s, REG_QUARTER, '0, 1'b0, '0};
  endfunction

  function automatic script_row_t known_row(in_item_t s, out_item_t w);
    return '{ROW_TICK, s, REG_QUARTER, '0, 1'b1, w};
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    return '{ROW_REG, '0, idx, val, 1'b0, '0};
  endfunction

  task automatic send_tick(input in_item_t stim, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    gap = (send_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= stim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_controller(stim);
    results_due.push_back(typed ? want : predicted);
  endtask

  // hold off new requests until every result is back
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_QUARTER: reg_quarter = val[PULSE_W-1:0];
      REG_HALF:    reg_half = val[PULSE_W-1:0];
      REG_SETTLE:  reg_settle = val[TICKS_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        want = results_due.pop_front();
        check_field("mode", want.mode, out_data.mode);
        check_field("motor_drive", want.motor_drive, out_data.motor_drive);
        check_field("servo_aim", want.servo_aim, out_data.servo_aim);
        check_field("vacuum_on", want.vacuum_on, out_data.vacuum_on);
        check_field("obstacle_flag", want.obstacle_flag, out_data.obstacle_flag);
      end
    end
  end

  initial begin : receiver_stall
    forever begin
      @(posedge clk);
      if (stall_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    script_row_t script[$];
    phase_t      plan[$];
    // stimulus fields: run, obstacle, pulse, coin
    script.push_back(known_row(4'b0000, '{MODE_OFF, DRV_STOP, AIM_CENTER, 1'b1, 1'b0}));
    script.push_back(known_row(4'b1000, '{MODE_MOVING, DRV_STOP, AIM_CENTER, 1'b1, 1'b0}));
    script.push_back(known_row(4'b1010, '{MODE_MOVING, DRV_FWD, AIM_CENTER, 1'b1, 1'b0}));
    script.push_back(known_row(4'b1100, '{MODE_NEED, DRV_FWD, AIM_CENTER, 1'b1, 1'b1}));
    script.push_back(known_row(4'b1001, '{MODE_MOVING, DRV_STOP, AIM_CENTER, 1'b1, 1'b0}));
    script.push_back(known_row(4'b0100, '{MODE_NEED, DRV_FWD, AIM_CENTER, 1'b1, 1'b1}));
    script.push_back(known_row(4'b1111, '{MODE_AVOID, DRV_STOP, AIM_CENTER, 1'b1, 1'b1}));
    script.push_back(known_row(4'b1000, '{MODE_LOOK_R, DRV_STOP, AIM_CENTER, 1'b1, 1'b1}));
    script.push_back(known_row(4'b1000, '{MODE_LOOK_R, DRV_STOP, AIM_RIGHT, 1'b1, 1'b1}));
    // zero settle: sample on the first tick after aiming
    script.push_back(reg_row(REG_SETTLE, 11'd0));
    script.push_back(plain_row(4'b1100));
    script.push_back(plain_row(4'b0100));
    script.push_back(plain_row(4'b1101));
    // turn around with a zero threshold, opening pulse ignored
    script.push_back(reg_row(REG_HALF, 11'd0));
    script.push_back(plain_row(4'b1010));
    script.push_back(plain_row(4'b1000));
    script.push_back(plain_row(4'b1010));
    script.push_back(plain_row(4'b1100));
    script.push_back(plain_row(4'b1100));
    script.push_back(plain_row(4'b1001));
    script.push_back(reg_row(REG_SETTLE, 11'd1));
    script.push_back(plain_row(4'b1000));
    script.push_back(plain_row(4'b1000));
    // top threshold: only the 64th pulse ends the turn
    script.push_back(reg_row(REG_QUARTER, 11'd63));
    script.push_back(plain_row(4'b1010));
    script.push_back(plain_row(4'b1010));

    plan.push_back('{6'd63, 6'd63, 11'd1, 200, 1'b1, 1'b1});
    plan.push_back('{6'd0, 6'd0, 11'd0, 160, 1'b0, 1'b0});
    plan.push_back('{QUARTER_RESET, HALF_RESET, 11'd4, 160, 1'b1, 1'b0});
    plan.push_back('{6'd2, 6'd5, 11'd2047, 100, 1'b0, 1'b0});
    repeat (5)
      plan.push_back('{6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                       11'($urandom_range(0, 12)), 140, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1))});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].op == ROW_REG) begin
        settle_idle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_tick(script[i].stim, script[i].typed, script[i].want);
      end
    end

    foreach (plan[p]) begin
      settle_idle();
      write_reg(REG_QUARTER, CFG_W'(plan[p].quarter));
      write_reg(REG_HALF, CFG_W'(plan[p].half));
      write_reg(REG_SETTLE, plan[p].settle);
      send_gaps = plan[p].gaps;
      stall_gaps = plan[p].stalls;
      repeat (plan[p].items) begin
        if ($urandom_range(0, 199) == 0) settle_idle();
        send_tick(shape_tick(), 1'b0, '0);
      end
    end

    settle_idle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
